@@ rtl/hcps_pkg.sv @@
// ----------------------------------------------------------------------------
// hcps_pkg
// Shared types, register indexes and mod 26 helpers for the pair stream core.
// ----------------------------------------------------------------------------
package hcps_pkg;

  localparam int unsigned MOD_N     = 26;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 5;

  localparam logic [7:0]       ASCII_A    = 8'h41;
  localparam logic [7:0]       ASCII_Z    = 8'h5A;
  localparam logic [7:0]       ASCII_LA   = 8'h61;
  localparam logic [7:0]       ASCII_LZ   = 8'h7A;
  localparam logic [IDX_W-1:0] PAD_LETTER = 5'd23;  // 'X' - 'A'

  localparam logic [CFG_IDX_W-1:0] REG_KEY00 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY01 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY10 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY11 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR   = 3'd4;

  // One unit of work handed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0] p0;
    logic [IDX_W-1:0] p1;
    logic             is_pair;   // 0: end marker only
    logic             text_end;
  } job_t;

  // Effective matrix (key or adjugate) and the scale applied afterwards
  typedef struct packed {
    logic [IDX_W-1:0] m00;
    logic [IDX_W-1:0] m01;
    logic [IDX_W-1:0] m10;
    logic [IDX_W-1:0] m11;
    logic [IDX_W-1:0] scale;
    logic             key_err;
  } key_t;

  // x mod 26 for x below 1300, by reciprocal multiply and one correction
  function automatic logic [IDX_W-1:0] mod26(input logic [10:0] x);
    logic [19:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 20'(x) * 20'd315;
    q    = prod[19:13];
    r    = x - 11'(q) * 11'(MOD_N);
    if (r >= 11'(MOD_N)) begin
      r = r - 11'(MOD_N);
    end
    return r[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] reduce26(input logic [IDX_W-1:0] v);
    return (v >= 5'(MOD_N)) ? v - 5'(MOD_N) : v;
  endfunction

  function automatic logic [IDX_W-1:0] neg26(input logic [IDX_W-1:0] v);
    return (v == '0) ? '0 : 5'(MOD_N) - v;
  endfunction

  // Multiplicative inverse mod 26, zero where none exists
  function automatic logic [IDX_W-1:0] inv26(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/hcps_key.sv @@
// ----------------------------------------------------------------------------
// hcps_key
// Configuration registers and the derived matrix, scale and key error flag.
// ----------------------------------------------------------------------------
module hcps_key (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hcps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hcps_pkg::CFG_DAT_W-1:0]  cfg_data,
  output hcps_pkg::key_t                  key
);
  import hcps_pkg::*;

  logic [IDX_W-1:0] k00_r, k01_r, k10_r, k11_r;
  logic             dir_r;

  logic [IDX_W-1:0] a, b, c, d;
  logic [IDX_W-1:0] m00_nxt, m01_nxt, m10_nxt, m11_nxt;
  logic [9:0]       ad_nxt, bc_nxt;
  logic [9:0]       ad_r, bc_r;
  logic [IDX_W-1:0] m00_r, m01_r, m10_r, m11_r;
  logic [IDX_W-1:0] det, inv;
  logic [IDX_W-1:0] scale_r;
  logic             kerr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k00_r <= 5'd1;
      k01_r <= 5'd0;
      k10_r <= 5'd0;
      k11_r <= 5'd1;
      dir_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY00: k00_r <= cfg_data;
        REG_KEY01: k01_r <= cfg_data;
        REG_KEY10: k10_r <= cfg_data;
        REG_KEY11: k11_r <= cfg_data;
        REG_DIR:   dir_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Decrypt runs the adjugate, then scales by the determinant's inverse
  always_comb begin
    a = reduce26(k00_r);
    b = reduce26(k01_r);
    c = reduce26(k10_r);
    d = reduce26(k11_r);
    ad_nxt = 10'(a) * 10'(d);
    bc_nxt = 10'(b) * 10'(c);
    if (dir_r) begin
      m00_nxt = d;
      m01_nxt = neg26(b);
      m10_nxt = neg26(c);
      m11_nxt = a;
    end else begin
      m00_nxt = a;
      m01_nxt = b;
      m10_nxt = c;
      m11_nxt = d;
    end
  end

  assign det = mod26(11'(ad_r) + 11'd650 - 11'(bc_r));
  assign inv = inv26(det);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_r    <= 10'd1;
      bc_r    <= 10'd0;
      m00_r   <= 5'd1;
      m01_r   <= 5'd0;
      m10_r   <= 5'd0;
      m11_r   <= 5'd1;
      scale_r <= 5'd1;
      kerr_r  <= 1'b0;
    end else begin
      ad_r    <= ad_nxt;
      bc_r    <= bc_nxt;
      m00_r   <= m00_nxt;
      m01_r   <= m01_nxt;
      m10_r   <= m10_nxt;
      m11_r   <= m11_nxt;
      scale_r <= dir_r ? inv : 5'd1;
      kerr_r  <= dir_r && (inv == '0);
    end
  end

  assign key = '{m00: m00_r, m01: m01_r, m10: m10_r, m11: m11_r,
                 scale: scale_r, key_err: kerr_r};

endmodule

@@ rtl/hcps_front.sv @@
// ----------------------------------------------------------------------------
// hcps_front
// Filters and folds characters, pairs letters and issues jobs to the queue.
// ----------------------------------------------------------------------------
module hcps_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_char_code,
  input  logic          in_text_end,
  input  logic          q_full,
  output logic          push,
  output hcps_pkg::job_t push_job
);
  import hcps_pkg::*;

  logic             pending_valid_r, pending_valid_nxt;
  logic [IDX_W-1:0] pending_letter_r, pending_letter_nxt;
  logic             accept;
  logic             is_upper, is_lower, is_letter;
  logic [IDX_W-1:0] idx;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_upper  = (in_char_code inside {[ASCII_A:ASCII_Z]});
  assign is_lower  = (in_char_code inside {[ASCII_LA:ASCII_LZ]});
  assign is_letter = is_upper || is_lower;
  assign idx       = is_upper ? 5'(in_char_code - ASCII_A) : 5'(in_char_code - ASCII_LA);

  always_comb begin
    pending_valid_nxt  = pending_valid_r;
    pending_letter_nxt = pending_letter_r;
    push               = 1'b0;
    push_job           = '{p0: pending_letter_r, p1: idx, is_pair: 1'b1,
                           text_end: in_text_end};
    if (accept) begin
      if (is_letter && pending_valid_r) begin
        push              = 1'b1;
        pending_valid_nxt = 1'b0;
      end else if (is_letter) begin
        if (in_text_end) begin
          push        = 1'b1;
          push_job.p0 = idx;
          push_job.p1 = PAD_LETTER;
        end else begin
          pending_valid_nxt  = 1'b1;
          pending_letter_nxt = idx;
        end
      end else if (in_text_end) begin
        push             = 1'b1;
        push_job.p1      = PAD_LETTER;
        push_job.is_pair = pending_valid_r;
      end
      if (in_text_end) begin
        pending_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_valid_r <= 1'b0;
    end else begin
      pending_valid_r <= pending_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pending_letter_r <= pending_letter_nxt;
  end

endmodule

@@ rtl/hcps_queue.sv @@
// ----------------------------------------------------------------------------
// hcps_queue
// Small job queue between front and back, registered storage.
// ----------------------------------------------------------------------------
module hcps_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hcps_pkg::job_t push_job,
  input  logic           pop,
  output hcps_pkg::job_t head_job,
  output logic           not_empty,
  output logic           full
);
  import hcps_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ rtl/hcps_back.sv @@
// ----------------------------------------------------------------------------
// hcps_back
// Pair transform pipeline and the output stage that serialises two letters.
// ----------------------------------------------------------------------------
module hcps_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  hcps_pkg::job_t q_job,
  output logic           pop,
  input  hcps_pkg::key_t key,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_letter,
  output logic           out_letter_valid,
  output logic           out_last_of_item,
  output logic           out_stream_done,
  output logic           out_key_error
);
  import hcps_pkg::*;

  // stage 1: matrix products summed
  logic             s1_valid_r, s1_pair_r, s1_end_r;
  logic [10:0]      s1_sum0_r, s1_sum1_r;
  // stage 2: reduced mod 26
  logic             s2_valid_r, s2_pair_r, s2_end_r;
  logic [IDX_W-1:0] s2_r0_r, s2_r1_r;
  // stage 3: scaled by key.scale (the determinant's inverse when decrypting, else 1)
  logic             s3_valid_r, s3_pair_r, s3_end_r;
  logic [9:0]       s3_t0_r, s3_t1_r;
  // output stage
  logic             o_valid_r, o_pair_r, o_end_r, o_err_r, o_idx_r;
  logic [IDX_W-1:0] o_c0_r, o_c1_r;

  logic             done_now, adv, drop;
  logic [IDX_W-1:0] sel;

  assign out_valid = o_valid_r;
  assign done_now  = o_valid_r && !out_stall && (!o_pair_r || o_idx_r);
  assign adv       = !o_valid_r || done_now;
  assign pop       = adv && q_valid;
  // a pair under a non-invertible decrypt key vanishes unless it ends the text
  assign drop      = s3_pair_r && key.key_err && !s3_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
      o_idx_r    <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid_r <= q_valid;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
        o_valid_r  <= s3_valid_r && !drop;
        o_idx_r    <= 1'b0;
      end else if (o_valid_r && !out_stall) begin
        o_idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pair_r <= q_job.is_pair;
      s1_end_r  <= q_job.text_end;
      s1_sum0_r <= 11'(key.m00) * 11'(q_job.p0) + 11'(key.m01) * 11'(q_job.p1);
      s1_sum1_r <= 11'(key.m10) * 11'(q_job.p0) + 11'(key.m11) * 11'(q_job.p1);
      s2_pair_r <= s1_pair_r;
      s2_end_r  <= s1_end_r;
      s2_r0_r   <= mod26(s1_sum0_r);
      s2_r1_r   <= mod26(s1_sum1_r);
      s3_pair_r <= s2_pair_r;
      s3_end_r  <= s2_end_r;
      s3_t0_r   <= 10'(s2_r0_r) * 10'(key.scale);
      s3_t1_r   <= 10'(s2_r1_r) * 10'(key.scale);
      o_pair_r  <= s3_pair_r && !key.key_err;
      o_end_r   <= s3_end_r;
      o_err_r   <= key.key_err;
      o_c0_r    <= mod26(11'(s3_t0_r));
      o_c1_r    <= mod26(11'(s3_t1_r));
    end
  end

  assign sel              = o_idx_r ? o_c1_r : o_c0_r;
  assign out_letter       = o_pair_r ? ASCII_A + 8'(sel) : 8'd0;
  assign out_letter_valid = o_pair_r;
  assign out_last_of_item = !o_pair_r || o_idx_r;
  assign out_stream_done  = o_end_r && (!o_pair_r || o_idx_r);
  assign out_key_error    = !o_pair_r && o_err_r;

endmodule

@@ rtl/hill_cipher_pair_stream_core.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_pair_stream_core
// 2x2 Hill cipher over a character stream, letter pairs mod 26.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | valid / stall    | char_code, text_end
//  out_    | output    | valid / stall    | letter, letter_valid, last_of_item,
//          |           |                  | stream_done, key_error
//  cfg_    | input     | valid / ready    | index, data (5 registers)
//
// One character is taken per cycle while the job queue has room. A pair
// leaves over two output transfers, a marker over one; the output stage sets
// that pace. Reset loads the identity key in encrypt mode and clears the
// pending letter. A stalled output holds the pipeline; the queue absorbs
// QUEUE_DEPTH jobs before in_stall rises.
// ----------------------------------------------------------------------------
module hill_cipher_pair_stream_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_char_code,
  input  logic                           in_text_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_letter,
  output logic                           out_letter_valid,
  output logic                           out_last_of_item,
  output logic                           out_stream_done,
  output logic                           out_key_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hcps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hcps_pkg::CFG_DAT_W-1:0] cfg_data
);
  import hcps_pkg::*;

  job_t push_job, head_job;
  key_t key;
  logic push, pop, q_not_empty, q_full;

  hcps_key u_key (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  hcps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_text_end  (in_text_end),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  hcps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  hcps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_not_empty),
    .q_job            (head_job),
    .pop              (pop),
    .key              (key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_letter       (out_letter),
    .out_letter_valid (out_letter_valid),
    .out_last_of_item (out_last_of_item),
    .out_stream_done  (out_stream_done),
    .out_key_error    (out_key_error)
  );

endmodule
